// File: design/cal_pkg.sv
// Package: widths, character codes, types and saturating helpers for the CIGAR length unit.
package cal_pkg;

   localparam int LenBits  = 31;
   localparam int OutBits  = 31;
   localparam int CharBits = 8;
   localparam int DigBits  = 4;

   typedef logic [LenBits-1:0]  len_type;
   typedef logic [OutBits-1:0]  out_len_type;
   typedef logic [CharBits-1:0] char_type;

   localparam len_type     LenMax = {LenBits{1'b1}};
   localparam out_len_type OutMax = {OutBits{1'b1}};

   localparam char_type CharM    = 8'h4D;
   localparam char_type CharI    = 8'h49;
   localparam char_type CharD    = 8'h44;
   localparam char_type CharN    = 8'h4E;
   localparam char_type CharS    = 8'h53;
   localparam char_type CharH    = 8'h48;
   localparam char_type CharP    = 8'h50;
   localparam char_type CharEq   = 8'h3D;
   localparam char_type CharX    = 8'h58;
   localparam char_type CharStar = 8'h2A;
   localparam char_type CharZero = 8'h30;
   localparam char_type CharNine = 8'h39;

   typedef struct packed {
      char_type cigar_char;
      logic     last_char;
   } req_data_type;

   typedef struct packed {
      out_len_type query_len;
      out_len_type ref_len;
      out_len_type align_len;
      logic        unsupported_seen;
      logic        unknown_seen;
   } rsp_data_type;

   function automatic len_type sat_add(input len_type a, input len_type b);
      logic [LenBits:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum[LenBits]) begin
         return LenMax;
      end
      return sum[LenBits-1:0];
   endfunction

   function automatic out_len_type out_sat(input len_type v);
      logic [LenBits+OutBits-1:0] wide;
      wide = {{OutBits{1'b0}}, v};
      if (wide > {{LenBits{1'b0}}, OutMax}) begin
         return OutMax;
      end
      return wide[OutBits-1:0];
   endfunction

endpackage

// File: design/cal_if.sv
// Interfaces: character request channel and length result channel.
interface cal_req_if import cal_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type cigar_char;
   logic     last_char;

   modport source (output valid, output cigar_char, output last_char, input ready);
   modport sink   (input valid, input cigar_char, input last_char, output ready);
endinterface

interface cal_rsp_if import cal_pkg::*; ();
   logic        valid;
   logic        ready;
   out_len_type query_len;
   out_len_type ref_len;
   out_len_type align_len;
   logic        unsupported_seen;
   logic        unknown_seen;

   modport source (output valid, output query_len, output ref_len, output align_len,
                   output unsupported_seen, output unknown_seen, input ready);
   modport sink   (input valid, input query_len, input ref_len, input align_len,
                   input unsupported_seen, input unknown_seen, output ready);
endinterface

// File: design/cal_in_stage.sv
// Input register: holds one character beat until the accumulator takes it.
module cal_in_stage import cal_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   cal_req_if.sink      req_bus,
   input  logic         take,
   output logic         in_valid,
   output req_data_type in_data
);

   logic         valid_ff, valid_in;
   req_data_type data_ff;
   logic         accept;

   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;
   assign valid_in      = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff.cigar_char <= req_bus.cigar_char;
         data_ff.last_char  <= req_bus.last_char;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

// File: design/cal_accum.sv
// Accumulator: run count, totals and flags, updated once per character beat.
module cal_accum import cal_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_data_type in_data,
   output rsp_data_type result
);

   logic    start_ff, start_in;
   logic    star_ff, star_in;
   len_type run_ff, run_in;
   len_type query_ff, query_in;
   len_type ref_ff, ref_in;
   len_type align_ff, align_in;
   logic    unsup_ff, unsup_in;
   logic    unknown_ff, unknown_in;

   char_type             c;
   logic                 star_now;
   logic                 add_q, add_r, add_a;
   logic [LenBits+3:0]   wide_run;
   logic [LenBits+3:0]   mac;

   assign c        = in_data.cigar_char;
   assign star_now = star_ff || (start_ff && (c == CharStar));
   assign wide_run = {{DigBits{1'b0}}, run_ff};
   assign mac      = (wide_run << 3) + (wide_run << 1) + {{LenBits{1'b0}}, c[DigBits-1:0]};

   always_comb begin
      start_in   = start_ff;
      star_in    = star_ff;
      run_in     = run_ff;
      query_in   = query_ff;
      ref_in     = ref_ff;
      align_in   = align_ff;
      unsup_in   = unsup_ff;
      unknown_in = unknown_ff;
      add_q      = 1'b0;
      add_r      = 1'b0;
      add_a      = 1'b0;
      result     = '0;

      if (fire) begin
         start_in = 1'b0;
         star_in  = star_now;
         if (!star_now) begin
            if (c inside {[CharZero:CharNine]}) begin
               if (mac > {{DigBits{1'b0}}, LenMax}) begin
                  run_in = LenMax;
               end else begin
                  run_in = mac[LenBits-1:0];
               end
            end else begin
               case (c)
                  CharM, CharEq, CharX: begin
                     add_q = 1'b1;
                     add_r = 1'b1;
                     add_a = 1'b1;
                  end
                  CharI: begin
                     add_q = 1'b1;
                     add_a = 1'b1;
                  end
                  CharD: begin
                     add_r = 1'b1;
                     add_a = 1'b1;
                  end
                  CharN: begin
                     add_r    = 1'b1;
                     unsup_in = 1'b1;
                  end
                  CharS, CharH, CharP: begin
                     unsup_in = 1'b1;
                  end
                  default: begin
                     unknown_in = 1'b1;
                  end
               endcase
               if (add_q) query_in = sat_add(query_ff, run_ff);
               if (add_r) ref_in   = sat_add(ref_ff, run_ff);
               if (add_a) align_in = sat_add(align_ff, run_ff);
               run_in = '0;
            end
            result.query_len        = out_sat(query_in);
            result.ref_len          = out_sat(ref_in);
            result.align_len        = out_sat(align_in);
            result.unsupported_seen = unsup_in;
            result.unknown_seen     = unknown_in;
         end
         if (in_data.last_char) begin
            start_in   = 1'b1;
            star_in    = 1'b0;
            run_in     = '0;
            query_in   = '0;
            ref_in     = '0;
            align_in   = '0;
            unsup_in   = 1'b0;
            unknown_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= 1'b1;
         star_ff    <= 1'b0;
         run_ff     <= '0;
         query_ff   <= '0;
         ref_ff     <= '0;
         align_ff   <= '0;
         unsup_ff   <= 1'b0;
         unknown_ff <= 1'b0;
      end else begin
         start_ff   <= start_in;
         star_ff    <= star_in;
         run_ff     <= run_in;
         query_ff   <= query_in;
         ref_ff     <= ref_in;
         align_ff   <= align_in;
         unsup_ff   <= unsup_in;
         unknown_ff <= unknown_in;
      end
   end

endmodule

// File: design/cal_out_stage.sv
// Result register: holds one length beat until the consumer takes it.
module cal_out_stage import cal_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_data_type data,
   cal_rsp_if.source    rsp_bus
);

   logic         valid_ff, valid_in;
   rsp_data_type data_ff;

   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_bus.valid            = valid_ff;
   assign rsp_bus.query_len        = data_ff.query_len;
   assign rsp_bus.ref_len          = data_ff.ref_len;
   assign rsp_bus.align_len        = data_ff.align_len;
   assign rsp_bus.unsupported_seen = data_ff.unsupported_seen;
   assign rsp_bus.unknown_seen     = data_ff.unknown_seen;

endmodule

// File: design/cigar_alignment_lengths_unit.sv
// CIGAR alignment length unit: one character beat per cycle in (if not stalled), one length beat per string out.
// The unit takes one CIGAR character per cycle while no string's last character is stalled.
// Each character is held in an input register until the accumulator takes it and updates
// its state (a multiply by ten and add for digits, or a saturating add into the totals for an
// operation). On a string's last character the length beat is loaded into the result
// register at that same edge. A string's last character waits in the input register only
// while the previous length beat is still held by the consumer; other characters are never
// held, but while it waits the input register accepts no new character.
module cigar_alignment_lengths_unit import cal_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cal_req_if.sink   req_bus,
   cal_rsp_if.source rsp_bus
);

   logic         in_valid;
   req_data_type in_data;
   logic         take;
   rsp_data_type result;

   assign take = in_valid && !(in_data.last_char && rsp_bus.valid && !rsp_bus.ready);

   cal_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .take     (take),
      .in_valid (in_valid),
      .in_data  (in_data)
   );

   cal_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .fire    (take),
      .in_data (in_data),
      .result  (result)
   );

   cal_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .load    (take && in_data.last_char),
      .data    (result),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: design/cal_checker.sv
// Checker: port-level properties of the CIGAR length unit, bound to the top level.
module cal_checker import cal_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input out_len_type rsp_query_len,
   input out_len_type rsp_align_len
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result beat dropped");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_align_len) && $stable(rsp_query_len))
      else $error("stalled result beat changed");

   a_align_covers_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_align_len >= rsp_query_len)
      else $error("alignment length below query length");

endmodule

bind cigar_alignment_lengths_unit cal_checker u_cal_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_query_len (rsp_bus.query_len),
   .rsp_align_len (rsp_bus.align_len)
);
